// ===== rtl/roc_pkg.sv =====
package roc_pkg;

	localparam int LANDMARK_SLOTS = 1024;
	localparam int SLOT_W = $clog2(LANDMARK_SLOTS);
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	localparam int CFG_W = 11;
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int IDX_W = 10;
	localparam int CNT_W = 32;
	localparam int ACC_W = 40;
	localparam int XW = 34;  // CORDIC x/y and multiplier operands
	localparam int ZW = 38;  // CORDIC angle
	localparam int PW = 2 * XW;
	localparam int RW = 31;  // square root result

	localparam logic [31:0] DEG7_TO_RAD_K = 32'd4024455254;
	localparam logic signed [ZW-1:0] HALF_PI_Q29 = ZW'(843314856);
	localparam logic signed [ZW-1:0] PI_Q29 = ZW'(1686629713);
	localparam logic signed [XW-1:0] GAIN_INV = XW'(652032874);
	localparam logic signed [XW-1:0] EARTH_R = XW'(6371000);
	localparam logic [RW-1:0] Q30_ONE = RW'(1) << 30;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_POINT  = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_ACCEPT, DP_SCAN, DP_RAD, DP_ROT, DP_KEEP,
		DP_M_SLAT, DP_M_SLON, DP_M_CC, DP_CC, DP_M_CCSQ, DP_A,
		DP_SQ_Y, DP_KEEP_Y, DP_SQ_X, DP_VEC, DP_M_DIST, DP_ACC, DP_PREV, DP_EMIT
	} dp_step_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FIN, S_SCAN, S_RAD, S_ROT, S_ROT_WAIT, S_KEEP,
		S_M_SLAT, S_M_SLON, S_M_CC, S_CC, S_M_CCSQ, S_A,
		S_SQ_Y, S_SQ_Y_WAIT, S_KEEP_Y, S_SQ_X, S_SQ_X_WAIT,
		S_VEC, S_VEC_WAIT, S_M_DIST, S_ACC, S_PREV
	} ctl_state_t;

	typedef struct packed {
		dp_step_t    step;
		logic [1:0]  sel;  // 0 dlat/2, 1 dlon/2, 2 lat1, 3 lat2
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic first;
		logic cordic_busy;
		logic sqrt_busy;
		logic out_free;
	} dp_stat_t;

	function automatic logic signed [ZW-1:0] atan_q29(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = ZW'(421657428);
			1: r = ZW'(248918915);
			2: r = ZW'(131521918);
			3: r = ZW'(66762579);
			4: r = ZW'(33510843);
			5: r = ZW'(16771758);
			6: r = ZW'(8387925);
			7: r = ZW'(4194219);
			8: r = ZW'(2097141);
			9: r = ZW'(1048575);
			default: r = (32'(i) <= 29) ? (ZW'(1) << (29 - 32'(i))) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/roc_if.sv =====
interface roc_in_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             opcode;
	logic signed [30:0]     latitude;
	logic signed [31:0]     longitude;
	logic [9:0]             entry_index;
	logic                   entry_named;
	modport source(output valid, opcode, latitude, longitude, entry_index, entry_named,
		input ready);
	modport sink(input valid, opcode, latitude, longitude, entry_index, entry_named,
		output ready);
endinterface

interface roc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_total;
	logic [31:0] landmark_hits;
	logic [31:0] distance_metres;
	modport source(output valid, point_total, landmark_hits, distance_metres, input ready);
	modport sink(input valid, point_total, landmark_hits, distance_metres, output ready);
endinterface

// ===== rtl/roc_cordic.sv =====
module roc_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              vect,
	input  logic signed [roc_pkg::XW-1:0]     x0,
	input  logic signed [roc_pkg::XW-1:0]     y0,
	input  logic signed [roc_pkg::ZW-1:0]     z0,
	output logic                              busy,
	output logic signed [roc_pkg::XW-1:0]     x_o,
	output logic signed [roc_pkg::XW-1:0]     y_o,
	output logic signed [roc_pkg::ZW-1:0]     z_o
);
	import roc_pkg::*;

	logic signed [XW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, at;
	logic [STEP_W-1:0]    i_q;
	logic                 busy_q, vect_q, neg_q, sigma;

	assign dx = x_q >>> i_q;
	assign dy = y_q >>> i_q;
	assign at = atan_q29(i_q);
	// rotation drives z to zero, vectoring drives y to zero
	assign sigma = vect_q ? y_q[XW-1] : ~z_q[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == STEP_W'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			vect_q <= vect;
			if (!vect && z0 > HALF_PI_Q29) begin
				z_q <= z0 - PI_Q29;
				neg_q <= 1'b1;
			end else if (!vect && z0 < -HALF_PI_Q29) begin
				z_q <= z0 + PI_Q29;
				neg_q <= 1'b1;
			end else begin
				z_q <= z0;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (sigma) begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + at;
			end
		end
	end

	assign busy = busy_q;
	assign x_o = neg_q ? -x_q : x_q;
	assign y_o = neg_q ? -y_q : y_q;
	assign z_o = z_q;
endmodule

// ===== rtl/roc_isqrt.sv =====
module roc_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [60:0]                 v,
	output logic                        busy,
	output logic [roc_pkg::RW-1:0]      root
);
	import roc_pkg::*;

	logic [63:0] v_q, res_q, bit_q, t;
	logic [4:0]  cnt_q;
	logic        busy_q;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= 64'(v);
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[RW-1:0];
endmodule

// ===== rtl/roc_dp.sv =====
module roc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  roc_pkg::dp_cmd_t                 cmd,
	output roc_pkg::dp_stat_t                stat,
	input  logic                             cfg_wr_en,
	input  logic [roc_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic [1:0]                       opcode,
	input  logic signed [roc_pkg::LAT_W-1:0] latitude,
	input  logic signed [roc_pkg::LON_W-1:0] longitude,
	input  logic [roc_pkg::IDX_W-1:0]        entry_index,
	input  logic                             entry_named,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [roc_pkg::CNT_W-1:0]        point_total,
	output logic [roc_pkg::CNT_W-1:0]        landmark_hits,
	output logic [roc_pkg::CNT_W-1:0]        distance_metres
);
	import roc_pkg::*;

	localparam int EW = LAT_W + LON_W + 1;

	// landmark table: {lat, lon, named}
	logic [EW-1:0]          mem [LANDMARK_SLOTS];
	logic [EW-1:0]          rd_s1;
	logic                   rdv_s1;

	logic [CFG_W-1:0]       in_use_q, n_lim, scan_q;
	logic                   found_q, issue;

	logic [CNT_W-1:0]       points_q, hits_q;
	logic [ACC_W-1:0]       acc_q;
	logic signed [LAT_W-1:0] prev_lat_q, pt_lat_q;
	logic signed [LON_W-1:0] prev_lon_q, pt_lon_q;
	logic                   first_q;

	logic signed [XW-1:0]   ma, mb;
	logic signed [PW-1:0]   mul_q;
	logic                   mul_en;

	logic signed [32:0]     d;
	logic [32:0]            mag;
	logic                   hi_q, neg_q, half_q;
	logic [33:0]            p, ph;
	logic signed [ZW-1:0]   z0;

	logic signed [XW-1:0]   sa_q, sb_q, c1_q, c2_q, sq_lat_q, sq_lon_q, cc_q;
	logic signed [35:0]     a_sum;
	logic [RW-1:0]          a_q, y_q, root;
	logic                   sq_start;
	logic [60:0]            sq_v;

	logic                   co_start, co_vect, co_busy, sq_busy;
	logic signed [XW-1:0]   co_x0, co_y0, co_x, co_y;
	logic signed [ZW-1:0]   co_z, zc;
	logic [33:0]            leg;
	logic [ACC_W:0]         acc_sum;

	logic                   out_valid_q;
	logic [CNT_W-1:0]       out_pts_q, out_hits_q, out_dist_q;

	assign n_lim = (in_use_q > CFG_W'(LANDMARK_SLOTS)) ? CFG_W'(LANDMARK_SLOTS) : in_use_q;
	assign issue = (cmd.step == DP_SCAN) && (scan_q < n_lim) && !found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_use_q <= '0;
		else if (cfg_wr_en)
			in_use_q <= cfg_wr_data;
	end

	// table write and registered scan read
	always_ff @(posedge clk) begin
		if (cmd.step == DP_ACCEPT && op_t'(opcode) == OP_LOAD &&
				32'(entry_index) < LANDMARK_SLOTS)
			mem[SLOT_W'(entry_index)] <= {latitude, longitude, entry_named};
		if (issue)
			rd_s1 <= mem[scan_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
			hits_q <= '0;
			acc_q <= '0;
			prev_lat_q <= '0;
			prev_lon_q <= '0;
			first_q <= 1'b0;
			scan_q <= '0;
			found_q <= 1'b0;
			rdv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step == DP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (cmd.step)
				DP_ACCEPT: begin
					if (op_t'(opcode) == OP_POINT) begin
						first_q <= (points_q == '0);
						if (points_q != CNT_MAX)
							points_q <= points_q + 1'b1;
						scan_q <= '0;
						found_q <= 1'b0;
						rdv_s1 <= 1'b0;
					end
				end
				DP_SCAN: begin
					rdv_s1 <= issue;
					if (issue)
						scan_q <= scan_q + 1'b1;
					if (rdv_s1 && !found_q &&
							rd_s1[EW-1:1] == {pt_lat_q, pt_lon_q}) begin
						found_q <= 1'b1;
						if (rd_s1[0] && hits_q != CNT_MAX)
							hits_q <= hits_q + 1'b1;
					end
				end
				DP_ACC: begin
					acc_q <= (acc_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
				end
				DP_PREV: begin
					prev_lat_q <= pt_lat_q;
					prev_lon_q <= pt_lon_q;
				end
				DP_EMIT: begin
					points_q <= '0;
					hits_q <= '0;
					acc_q <= '0;
					prev_lat_q <= '0;
					prev_lon_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// angle source for radian conversion
	always_comb begin
		case (cmd.sel)
			2'd0: d = 33'(pt_lat_q) - 33'(prev_lat_q);
			2'd1: d = 33'(pt_lon_q) - 33'(prev_lon_q);
			2'd2: d = 33'(prev_lat_q);
			default: d = 33'(pt_lat_q);
		endcase
		mag = d[32] ? 33'(-d) : 33'(d);
	end

	assign p = 34'(hi_q ? DEG7_TO_RAD_K : 32'd0) + 34'(mul_q[63:32]);
	assign ph = half_q ? (p >> 1) : p;
	assign z0 = neg_q ? -ZW'(ph) : ZW'(ph);

	assign zc = co_z[ZW-1] ? '0 : co_z;
	assign leg = mul_q[53:20];
	assign acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(leg);
	assign a_sum = 36'(sq_lat_q) + 36'(mul_q >>> 30);

	always_comb begin
		mul_en = 1'b1;
		ma = '0;
		mb = '0;
		case (cmd.step)
			DP_RAD: begin
				ma = XW'(mag[31:0]);
				mb = XW'(DEG7_TO_RAD_K);
			end
			DP_M_SLAT: begin
				ma = sa_q;
				mb = sa_q;
			end
			DP_M_SLON: begin
				ma = sb_q;
				mb = sb_q;
			end
			DP_M_CC: begin
				ma = c1_q;
				mb = c2_q;
			end
			DP_M_CCSQ: begin
				ma = cc_q;
				mb = sq_lon_q;
			end
			DP_M_DIST: begin
				ma = XW'(zc);
				mb = EARTH_R;
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			mul_q <= ma * mb;
		if (cmd.step == DP_ACCEPT) begin
			pt_lat_q <= latitude;
			pt_lon_q <= longitude;
		end
		case (cmd.step)
			DP_RAD: begin
				hi_q <= mag[32];
				neg_q <= d[32];
				half_q <= ~cmd.sel[1];
			end
			DP_KEEP: begin
				case (cmd.sel)
					2'd0: sa_q <= co_y;
					2'd1: sb_q <= co_y;
					2'd2: c1_q <= co_x;
					default: c2_q <= co_x;
				endcase
			end
			DP_M_SLON: sq_lat_q <= XW'(mul_q >>> 30);
			DP_M_CC: sq_lon_q <= XW'(mul_q >>> 30);
			DP_CC: cc_q <= XW'(mul_q >>> 30);
			DP_A: begin
				if (a_sum < 0)
					a_q <= '0;
				else if (a_sum > 36'(Q30_ONE))
					a_q <= Q30_ONE;
				else
					a_q <= a_sum[RW-1:0];
			end
			DP_KEEP_Y: y_q <= root;
			DP_EMIT: begin
				out_pts_q <= points_q;
				out_hits_q <= hits_q;
				out_dist_q <= acc_q[ACC_W-1:8];
			end
			default: ;
		endcase
	end

	assign sq_start = (cmd.step == DP_SQ_Y) || (cmd.step == DP_SQ_X);
	assign sq_v = (cmd.step == DP_SQ_Y) ? {a_q, 30'd0} : {Q30_ONE - a_q, 30'd0};

	roc_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .v(sq_v),
		.busy(sq_busy), .root(root)
	);

	assign co_start = (cmd.step == DP_ROT) || (cmd.step == DP_VEC);
	assign co_vect = (cmd.step == DP_VEC);
	assign co_x0 = co_vect ? XW'(root) : GAIN_INV;
	assign co_y0 = co_vect ? XW'(y_q) : '0;

	roc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(co_start), .vect(co_vect),
		.x0(co_x0), .y0(co_y0), .z0(co_vect ? '0 : z0),
		.busy(co_busy), .x_o(co_x), .y_o(co_y), .z_o(co_z)
	);

	always_comb begin
		stat.scan_done = !rdv_s1 && (found_q || scan_q >= n_lim);
		stat.first = first_q;
		stat.cordic_busy = co_busy;
		stat.sqrt_busy = sq_busy;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign point_total = out_pts_q;
	assign landmark_hits = out_hits_q;
	assign distance_metres = out_dist_q;
endmodule

// ===== rtl/roc_ctrl.sv =====
module roc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_opcode,
	output logic               in_ready,
	input  roc_pkg::dp_stat_t  stat,
	output roc_pkg::dp_cmd_t   cmd
);
	import roc_pkg::*;

	ctl_state_t state_q, state_d;
	logic [1:0] ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ang_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN)
				ang_q <= '0;
			else if (state_q == S_KEEP)
				ang_q <= ang_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (op_t'(in_opcode))
						OP_POINT:  state_d = S_SCAN;
						OP_FINISH: state_d = S_FIN;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_FIN:       if (stat.out_free) state_d = S_IDLE;
			S_SCAN:      if (stat.scan_done) state_d = stat.first ? S_PREV : S_RAD;
			S_RAD:       state_d = S_ROT;
			S_ROT:       state_d = S_ROT_WAIT;
			S_ROT_WAIT:  if (!stat.cordic_busy) state_d = S_KEEP;
			S_KEEP:      state_d = (ang_q == 2'd3) ? S_M_SLAT : S_RAD;
			S_M_SLAT:    state_d = S_M_SLON;
			S_M_SLON:    state_d = S_M_CC;
			S_M_CC:      state_d = S_CC;
			S_CC:        state_d = S_M_CCSQ;
			S_M_CCSQ:    state_d = S_A;
			S_A:         state_d = S_SQ_Y;
			S_SQ_Y:      state_d = S_SQ_Y_WAIT;
			S_SQ_Y_WAIT: if (!stat.sqrt_busy) state_d = S_KEEP_Y;
			S_KEEP_Y:    state_d = S_SQ_X;
			S_SQ_X:      state_d = S_SQ_X_WAIT;
			S_SQ_X_WAIT: if (!stat.sqrt_busy) state_d = S_VEC;
			S_VEC:       state_d = S_VEC_WAIT;
			S_VEC_WAIT:  if (!stat.cordic_busy) state_d = S_M_DIST;
			S_M_DIST:    state_d = S_ACC;
			S_ACC:       state_d = S_PREV;
			S_PREV:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.sel = ang_q;
		cmd.step = DP_NOP;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.step = DP_ACCEPT;
			end
			S_FIN:    if (stat.out_free) cmd.step = DP_EMIT;
			S_SCAN:   cmd.step = DP_SCAN;
			S_RAD:    cmd.step = DP_RAD;
			S_ROT:    cmd.step = DP_ROT;
			S_KEEP:   cmd.step = DP_KEEP;
			S_M_SLAT: cmd.step = DP_M_SLAT;
			S_M_SLON: cmd.step = DP_M_SLON;
			S_M_CC:   cmd.step = DP_M_CC;
			S_CC:     cmd.step = DP_CC;
			S_M_CCSQ: cmd.step = DP_M_CCSQ;
			S_A:      cmd.step = DP_A;
			S_SQ_Y:   cmd.step = DP_SQ_Y;
			S_KEEP_Y: cmd.step = DP_KEEP_Y;
			S_SQ_X:   cmd.step = DP_SQ_X;
			S_VEC:    cmd.step = DP_VEC;
			S_M_DIST: cmd.step = DP_M_DIST;
			S_ACC:    cmd.step = DP_ACC;
			S_PREV:   cmd.step = DP_PREV;
			default:  cmd.step = DP_NOP;
		endcase
	end
endmodule

// ===== rtl/route_odometer_with_landmark_count.sv =====
// Load and unknown words take only the accept step. Finish waits while the result register is full.
// Track point: an accept step, then a scan of the landmarks in use that stops at the first match.
// First point of a route skips the leg math; later points add four 24-step CORDIC rotations and one
// 24-step vectoring pass on a shared CORDIC unit, two 32-step square roots, multiplies.
// One word in flight at a time.
// arst_n clears counters, accumulator, previous point, config and control; table is not cleared.
module route_odometer_with_landmark_count (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [roc_pkg::CFG_W-1:0] cfg_wr_data,
	roc_in_if.sink                    items,
	roc_out_if.source                 results
);
	import roc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	// sequencer: owns the input handshake and steps the datapath
	roc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(items.valid),
		.in_opcode(items.opcode),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	assign items.ready = in_ready;

	// datapath: landmark table, counters, angle math, output register
	roc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.opcode(items.opcode),
		.latitude(items.latitude),
		.longitude(items.longitude),
		.entry_index(items.entry_index),
		.entry_named(items.entry_named),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.point_total(results.point_total),
		.landmark_hits(results.landmark_hits),
		.distance_metres(results.distance_metres)
	);
endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import roc_pkg::*;

	// Long enough for a point that scans 1024 landmarks, and for the
	// receiver hold-off, with plenty of margin.
	localparam int STALL_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 4000;
	// Covers the longest single word in the block (full scan plus leg math).
	localparam int DRAIN_CYCLES = 1300;
	// Slots loaded up front; no phase searches beyond them.
	localparam int TABLE_FILL = 48;
	localparam int PHASE_LEN [7] = '{80, 15, 40, 70, 8, 17, 230};
	localparam int PHASE_CFG [7] = '{16, 48, 1, 32, 47, 0, 4};

	typedef struct {
		op_t                opcode;
		logic signed [30:0] latitude;
		logic signed [31:0] longitude;
		logic [9:0]         entry_index;
		logic               entry_named;
	} word_t;

	typedef struct {
		logic [31:0] point_total;
		logic [31:0] landmark_hits;
		logic [31:0] distance_metres;
	} summary_t;

	// Directed row: a word plus, where it is obvious, the summary it must give.
	typedef struct {
		word_t    w;
		bit       typed;
		summary_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	roc_in_if  items();
	roc_out_if results();

	route_odometer_with_landmark_count DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.items      (items.sink),
		.results    (results.source)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------
	// Odometer model: table, counters, Q32.8 accumulator, last point
	// ---------------------------------------------------------------
	longint          lm_lat [LANDMARK_SLOTS];
	longint          lm_lon [LANDMARK_SLOTS];
	bit              lm_named [LANDMARK_SLOTS];
	logic [31:0]     pts_count;
	logic [31:0]     hit_count;
	longint unsigned path_q8;
	longint          last_lat;
	longint          last_lon;
	int              search_len;

	summary_t summaries_due[$];

	int  fail_count;
	int  n_words, n_points, n_loads, n_summaries, n_hit_points;
	bit  calm;      // no idling on either side
	bit  hold_req;  // receiver holds off for a long stretch
	int  stall_cycles;

	function automatic longint atan_step(int i);
		longint head [10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
			16771758, 8387925, 4194219, 2097141, 1048575};
		if (i < 10)
			return head[i];
		if (i <= 29)
			return longint'(1) << (29 - i);
		return 0;
	endfunction

	// 1e-7 degree to Q3.29 radians, then divided by 2^extra
	function automatic longint deg7_to_q29(longint d, int extra);
		longint unsigned mag, hi, lo, p;
		mag = (d < 0) ? longint'(-d) : d;
		hi = mag >> 32;
		lo = mag & 64'hFFFF_FFFF;
		p = hi * 64'd4024455254 + ((lo * 64'd4024455254) >> 32);
		p = p >> extra;
		return (d < 0) ? -longint'(p) : longint'(p);
	endfunction

	// rotation-mode CORDIC, angles beyond +-pi/2 folded by pi
	task automatic cordic_sin_cos(input longint angle, output longint s, output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		z = angle;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 843314856) begin
			z -= 1686629713;
			flip = 1;
		end else if (z < -843314856) begin
			z += 1686629713;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x -= dy;
				y += dx;
				z -= atan_step(i);
			end else begin
				x += dy;
				y -= dx;
				z += atan_step(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// haversine leg in Q32.8 metres
	task automatic haversine_q8(input longint lat1, input longint lon1,
			input longint lat2, input longint lon2, output longint unsigned leg);
		longint s, c, s1, c1, s2, c2, sq_lat, sq_lon, cc, a, x, y, z, dx, dy;
		cordic_sin_cos(deg7_to_q29(lat2 - lat1, 1), s, c);
		sq_lat = (s * s) >>> 30;
		cordic_sin_cos(deg7_to_q29(lon2 - lon1, 1), s, c);
		sq_lon = (s * s) >>> 30;
		cordic_sin_cos(deg7_to_q29(lat1, 0), s1, c1);
		cordic_sin_cos(deg7_to_q29(lat2, 0), s2, c2);
		cc = (c1 * c2) >>> 30;
		a = sq_lat + ((cc * sq_lon) >>> 30);
		if (a < 0)
			a = 0;
		if (a > (longint'(1) << 30))
			a = longint'(1) << 30;
		y = longint'(int_sqrt(longint'(a) << 30));
		x = longint'(int_sqrt(((longint'(1) << 30) - a) << 30));
		z = 0;
		// vectoring: atan2(sqrt(a), sqrt(1-a))
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy;
				y -= dx;
				z += atan_step(i);
			end else begin
				x -= dy;
				y += dx;
				z -= atan_step(i);
			end
		end
		if (z < 0)
			z = 0;
		leg = (64'd6371000 * longint'(z)) >> 20;
	endtask

	task automatic odometer_step(input word_t w, output bit emits, output summary_t s);
		longint lat, lon;
		longint unsigned leg;
		int n;
		bit first;
		lat = w.latitude;
		lon = w.longitude;
		emits = 0;
		s = '{default: '0};
		case (w.opcode)
			OP_LOAD: begin
				lm_lat[w.entry_index] = lat;
				lm_lon[w.entry_index] = lon;
				lm_named[w.entry_index] = w.entry_named;
			end
			OP_POINT: begin
				n = (search_len > LANDMARK_SLOTS) ? LANDMARK_SLOTS : search_len;
				first = (pts_count == 0);
				if (pts_count != CNT_MAX)
					pts_count++;
				// lowest matching in-use entry decides
				for (int k = 0; k < n; k++) begin
					if (lm_lat[k] == lat && lm_lon[k] == lon) begin
						if (lm_named[k]) begin
							n_hit_points++;
							if (hit_count != CNT_MAX)
								hit_count++;
						end
						break;
					end
				end
				if (!first) begin
					haversine_q8(last_lat, last_lon, lat, lon, leg);
					path_q8 += leg;
					if (path_q8 > longint'(ACC_MAX))
						path_q8 = ACC_MAX;
				end
				last_lat = lat;
				last_lon = lon;
			end
			OP_FINISH: begin
				emits = 1;
				s.point_total = pts_count;
				s.landmark_hits = hit_count;
				s.distance_metres = path_q8[39:8];
				pts_count = 0;
				hit_count = 0;
				path_q8 = 0;
				last_lat = 0;
				last_lon = 0;
			end
			default: ;  // unknown opcode: no effect
		endcase
	endtask

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	task automatic send_word(input word_t w, input bit typed, input summary_t want);
		bit emits;
		summary_t s;
		if (!calm && $urandom_range(99) < 24) begin
			@(negedge clk);
			items.valid = 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		items.valid       = 1'b1;
		items.opcode      = w.opcode;
		items.latitude    = w.latitude;
		items.longitude   = w.longitude;
		items.entry_index = w.entry_index;
		items.entry_named = w.entry_named;
		do
			@(posedge clk);
		while (!items.ready);
		// accepted at this edge
		n_words++;
		if (w.opcode == OP_POINT)
			n_points++;
		if (w.opcode == OP_LOAD)
			n_loads++;
		odometer_step(w, emits, s);
		if (emits)
			summaries_due.insert(summaries_due.size(), typed ? want : s);
	endtask

	task automatic send(input word_t w);
		send_word(w, 1'b0, '{default: '0});
	endtask

	task automatic go_quiet;
		@(negedge clk);
		items.valid = 1'b0;
	endtask

	// wait out every summary, then any point still in the datapath
	task automatic drain;
		go_quiet();
		while (summaries_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_search_len(input int n);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = CFG_W'(n);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		search_len = n;
	endtask

	function automatic word_t mk(op_t op, longint lat, longint lon, int idx, bit named);
		word_t w;
		w.opcode = op;
		w.latitude = lat[30:0];
		w.longitude = lon[31:0];
		w.entry_index = idx[9:0];
		w.entry_named = named;
		return w;
	endfunction

	function automatic longint rand_lat();
		return longint'($urandom_range(1800000000)) - 900000000;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(32'd3600000000)) - 1800000000;
	endfunction

	// random word with weighted opcode; points often revisit landmarks
	// or step close to the last point
	function automatic word_t rand_word(int n);
		int pick, k, in_use;
		longint lat, lon;
		in_use = (n > LANDMARK_SLOTS) ? LANDMARK_SLOTS : n;
		pick = $urandom_range(99);
		if (pick < 8)
			return mk(OP_LOAD, rand_lat(), rand_lon(),
				(in_use > 0 && $urandom_range(1)) ? $urandom_range(in_use - 1)
					: $urandom_range(1023), $urandom_range(1));
		if (pick < 10)
			return mk(OP_NONE, $urandom, $urandom, $urandom, $urandom_range(1));
		if (pick < 18)
			return mk(OP_FINISH, $urandom, $urandom, $urandom, $urandom_range(1));
		pick = $urandom_range(99);
		if (in_use > 0 && pick < 35) begin
			k = $urandom_range(in_use - 1);
			lat = lm_lat[k];
			lon = lm_lon[k];
		end else if (pick < 65) begin
			lat = last_lat + longint'($urandom_range(20000)) - 10000;
			lon = last_lon + longint'($urandom_range(20000)) - 10000;
		end else if (pick < 75) begin
			// any value of the full field width, not only the legal ranges
			lat = longint'($signed(31'($urandom)));
			lon = longint'($signed($urandom));
		end else begin
			lat = rand_lat();
			lon = rand_lon();
		end
		return mk(OP_POINT, lat, lon, $urandom, $urandom_range(1));
	endfunction

	// ---------------------------------------------------------------
	// Receiver side: random stalls, quiet stretches, one long hold-off
	// ---------------------------------------------------------------
	initial begin
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				results.ready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else begin
				results.ready = calm || ($urandom_range(99) >= 24);
			end
		end
	end

	// Summary checker: compares each accepted word with the oldest expectation.
	always @(posedge clk) begin
		summary_t want;
		if (arst_n && results.valid && results.ready) begin
			if (summaries_due.size() == 0) begin
				$error("unexpected summary: points %0d hits %0d metres %0d",
					results.point_total, results.landmark_hits, results.distance_metres);
				fail_count++;
			end else begin
				want = summaries_due.pop_front();
				n_summaries++;
				if (results.point_total !== want.point_total) begin
					$error("point_total: expected %0d, got %0d",
						want.point_total, results.point_total);
					fail_count++;
				end
				if (results.landmark_hits !== want.landmark_hits) begin
					$error("landmark_hits: expected %0d, got %0d",
						want.landmark_hits, results.landmark_hits);
					fail_count++;
				end
				if (results.distance_metres !== want.distance_metres) begin
					$error("distance_metres: expected %0d, got %0d",
						want.distance_metres, results.distance_metres);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		row_t rows[$];
		word_t w;
		longint flat, flon;
		bit nm;

		items.valid = 1'b0;
		items.opcode = OP_NONE;
		items.latitude = '0;
		items.longitude = '0;
		items.entry_index = '0;
		items.entry_named = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		calm = 0;
		hold_req = 0;
		fail_count = 0;
		stall_cycles = 0;
		pts_count = 0;
		hit_count = 0;
		path_q8 = 0;
		last_lat = 0;
		last_lon = 0;
		search_len = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the searched part of the table so no search reads an unwritten slot.
		// Slots 2/3 and 5/9 share a location with opposite name flags:
		// the lower slot must decide the hit.
		for (int i = 0; i < TABLE_FILL; i++) begin
			flat = rand_lat();
			flon = rand_lon();
			nm = $urandom_range(1);
			if (i == 3 || i == 9) begin
				flat = lm_lat[i == 3 ? 2 : 5];
				flon = lm_lon[i == 3 ? 2 : 5];
				nm = !lm_named[i == 3 ? 2 : 5];
			end
			send(mk(OP_LOAD, flat, flon, i, nm));
		end

		// Directed rows; landmarks_in_use is still 0 from reset.
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 1, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 0, 0, 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 1, '{1, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 900000000, 1800000000, 1023, 1), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, -900000000, -1800000000, 0, 0), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 900000000, -1800000000, 0, 0), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 0, '{0, 0, 0}});
		// repeated point: zero-length leg
		rows.insert(rows.size(), '{mk(OP_POINT, 1000000, 1000000, 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 1000000, 1000000, 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 0, '{0, 0, 0}});
		// unknown opcode with every field bit set does nothing
		rows.insert(rows.size(), '{mk(OP_NONE, -1, -1, 1023, 1), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, -1, -1, 1023, 1), 1, '{0, 0, 0}});
		// coordinates beyond the legal range, full field width
		rows.insert(rows.size(), '{mk(OP_POINT, -(64'sd1 << 30), -(64'sd1 << 31), 0, 0), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, (64'sd1 << 30) - 1, (64'sd1 << 31) - 1, 0, 0),
			0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 0, -(64'sd1 << 31), 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 0, '{0, 0, 0}});
		// load into the top slot, named and unnamed, then a quick route
		rows.insert(rows.size(), '{mk(OP_LOAD, 123456789, -987654321, 1023, 1), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_LOAD, -123456789, 987654321, 1023, 0), 0,
			'{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 515000000, -1270000, 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_POINT, 488566000, 23522000, 0, 0), 0, '{0, 0, 0}});
		rows.insert(rows.size(), '{mk(OP_FINISH, 0, 0, 0, 0), 0, '{0, 0, 0}});
		foreach (rows[r])
			send_word(rows[r].w, rows[r].typed, rows[r].want);

		// Random phases, each under its own landmark count.
		for (int p = 0; p < 7; p++) begin
			set_search_len(PHASE_CFG[p]);
			calm = (p == 3);
			for (int k = 0; k < PHASE_LEN[p]; k++) begin
				if (p == 0 && k == 40) begin
					// long receiver hold-off: two summaries back up and
					// the input has to stall behind them
					hold_req = 1;
					send(mk(OP_FINISH, 0, 0, 0, 0));
					send(mk(OP_POINT, rand_lat(), rand_lon(), 0, 0));
					send(mk(OP_FINISH, 0, 0, 0, 0));
					send(mk(OP_POINT, rand_lat(), rand_lon(), 0, 0));
				end else if (p == 6) begin
					// near-antipodal hops: the accumulator must saturate
					w = mk(OP_POINT, longint'($urandom_range(2000)) - 1000,
						(k % 2) ? 1800000000 - longint'($urandom_range(1000)) : 0,
						$urandom, $urandom_range(1));
					send(w);
				end else begin
					send(rand_word(PHASE_CFG[p]));
				end
			end
			send(mk(OP_FINISH, 0, 0, 0, 0));
		end
		calm = 0;

		drain();
		$display("Covered %0d words: %0d points (%0d landmark hits), %0d loads, %0d summaries,",
			n_words, n_points, n_hit_points, n_loads, n_summaries);
		$display("landmark counts 0 to 48, long receiver hold-off, saturating route.");
		if (fail_count == 0 && summaries_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/roc_pkg.sv
rtl/roc_if.sv
rtl/roc_cordic.sv
rtl/roc_isqrt.sv
rtl/roc_dp.sv
rtl/roc_ctrl.sv
rtl/route_odometer_with_landmark_count.sv
bench/testbench.sv
